// ===== rtl/rcmr_pkg.sv =====
// Package for the rod cutting revenue block: field widths, the revenue ceiling
// and the control struct of the shared add-compare unit. No dependencies.
package rcmr_pkg;

   localparam int PRICE_W = 16;
   localparam int REV_W   = 22;
   localparam int LEN_W   = 7;

   // Largest revenue the result field can carry; sums saturate here.
   localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

   typedef struct packed {
      logic clear;     // start a new maximum at zero
      logic enable;    // fold one candidate into the maximum
      logic rev_zero;  // the revenue operand stands for length zero
   } rcmr_acc_ctrl_type;

endpackage

// ===== rtl/rcmr_max_acc.sv =====
// Shared add, saturate and compare unit of the rod cutting revenue block.
// Depends on rcmr_pkg.
module rcmr_max_acc (
   input  logic                           clock,
   input  rcmr_pkg::rcmr_acc_ctrl_type    ctrl,
   input  logic [rcmr_pkg::PRICE_W-1:0]   price,
   input  logic [rcmr_pkg::REV_W-1:0]     revenue,
   output logic [rcmr_pkg::REV_W-1:0]     best
);
   import rcmr_pkg::*;

   logic [REV_W-1:0] best_ff;
   logic [REV_W-1:0] best_in;
   logic [REV_W-1:0] rev_eff;
   logic [REV_W:0]   sum;
   logic [REV_W-1:0] cand;

   always_comb begin
      rev_eff = ctrl.rev_zero ? '0 : revenue;
      sum     = {{(REV_W + 1 - PRICE_W){1'b0}}, price} + {1'b0, rev_eff};
      cand    = sum[REV_W] ? REV_MAX : sum[REV_W-1:0];
      best_in = best_ff;
      if (ctrl.clear) begin
         best_in = '0;
      end else if (ctrl.enable && (cand > best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

// ===== rtl/rod_cutting_max_revenue.sv =====
// Top level of the rod cutting revenue block: handshakes, sequencer and the
// price and revenue memories. Depends on rcmr_pkg and rcmr_max_acc.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_price[15:0], req_last
//   rsp      out        rsp_valid/rsp_ready  rsp_best_revenue[21:0], rsp_rod_length[6:0],
//                                            rsp_end_of_rod, rsp_too_long
//
// The result of an item for rod length L is loaded in S_DONE, after L add-compare steps
// on the shared unit, fed from S_SCAN through the registered memory read and S_DRAIN;
// the finished revenue is stored in S_DONE too. A rejected item goes from S_IDLE
// straight to S_DONE. The next item is taken only once the block is back in S_IDLE.
// Synchronous reset clears the sequencer, the length count and the result valid.
// The block takes no item while it scans; a result waits in S_DONE for the output.
module rod_cutting_max_revenue #(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rcmr_pkg::PRICE_W-1:0]  req_price,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcmr_pkg::REV_W-1:0]    rsp_best_revenue,
   output logic [rcmr_pkg::LEN_W-1:0]    rsp_rod_length,
   output logic                          rsp_end_of_rod,
   output logic                          rsp_too_long
);
   import rcmr_pkg::*;

   // Address width of the memories and width of a count that reaches MAX_LEN.
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
   localparam logic [CW-1:0] ONE     = CW'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;   // prices held for the current rod
   logic [CW-1:0]     len_ff, len_in;       // length of the item at work
   logic [CW-1:0]     j_ff, j_in;           // piece length under test
   logic              last_ff, last_in;
   logic              rej_ff, rej_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_zero_ff, rd_zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [REV_W-1:0]  rsp_best_ff, rsp_best_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_end_ff, rsp_end_in;
   logic              rsp_long_ff, rsp_long_in;

   // Memories, one write and one registered read each per cycle.
   logic [PRICE_W-1:0] price_mem [MAX_LEN];
   logic [REV_W-1:0]   rev_mem   [MAX_LEN];
   logic [PRICE_W-1:0] price_rd_ff;
   logic [REV_W-1:0]   rev_rd_ff;

   logic [CW-1:0]      cnt_less1;
   logic [CW-1:0]      j_less1;
   logic [CW-1:0]      len_less1;
   logic [CW-1:0]      diff;
   logic [CW-1:0]      diff_less1;
   logic [AW-1:0]      wr_price_addr;
   logic [AW-1:0]      wr_rev_addr;
   logic [AW-1:0]      rd_price_addr;
   logic [AW-1:0]      rd_rev_addr;
   logic               accept;
   logic               out_free;

   rcmr_acc_ctrl_type  acc_ctrl;
   logic [REV_W-1:0]   acc_best;

   // Address arithmetic. The revenue operand of the step j = len stands for
   // length zero, so its address is parked at entry zero and masked later.
   always_comb begin
      cnt_less1     = count_ff;
      j_less1       = j_ff - ONE;
      len_less1     = len_ff - ONE;
      diff          = len_ff - j_ff;
      diff_less1    = diff - ONE;
      wr_price_addr = cnt_less1[AW-1:0];
      wr_rev_addr   = len_less1[AW-1:0];
      rd_price_addr = j_less1[AW-1:0];
      rd_rev_addr   = (diff == '0) ? '0 : diff_less1[AW-1:0];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      j_in        = j_ff;
      last_in     = last_ff;
      rej_in      = rej_ff;
      rd_valid_in = 1'b0;
      rd_zero_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_best_in = rsp_best_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_long_in = rsp_long_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               if (count_ff >= MAX_CNT) begin
                  // The rod is full: the price is dropped and the count stays, unless the item is the last of the rod.
                  rej_in   = 1'b1;
                  count_in = req_last ? '0 : count_ff;
                  state_in = S_DONE;
               end else begin
                  rej_in   = 1'b0;
                  len_in   = count_ff + ONE;
                  j_in     = ONE;
                  count_in = req_last ? '0 : (count_ff + ONE);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_valid_in = 1'b1;
            rd_zero_in  = (j_ff == len_ff);
            j_in        = j_ff + ONE;
            if (j_ff == len_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last pair of operands reaches the unit in this cycle.
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = rej_ff ? '0 : acc_best;
               rsp_len_in   = rej_ff ? '0 : LEN_W'(len_ff);
               rsp_end_in   = last_ff;
               rsp_long_in  = rej_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      j_ff        <= j_in;
      last_ff     <= last_in;
      rej_ff      <= rej_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_best_ff <= rsp_best_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_long_ff <= rsp_long_in;
   end

   // The new price is written at acceptance, so the scan sees it at j = len.
   always_ff @(posedge clock) begin
      if (accept && (count_ff < MAX_CNT)) begin
         price_mem[wr_price_addr] <= req_price;
      end
      if (state_ff == S_SCAN) begin
         price_rd_ff <= price_mem[rd_price_addr];
      end
   end

   // The finished revenue is stored while the result waits in S_DONE.
   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && !rej_ff) begin
         rev_mem[wr_rev_addr] <= acc_best;
      end
      if (state_ff == S_SCAN) begin
         rev_rd_ff <= rev_mem[rd_rev_addr];
      end
   end

   always_comb begin
      acc_ctrl.clear    = accept;
      acc_ctrl.enable   = rd_valid_ff;
      acc_ctrl.rev_zero = rd_zero_ff;
   end

   rcmr_max_acc u_acc (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .price   (price_rd_ff),
      .revenue (rev_rd_ff),
      .best    (acc_best)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_revenue = rsp_best_ff;
   assign rsp_rod_length   = rsp_len_ff;
   assign rsp_end_of_rod   = rsp_end_ff;
   assign rsp_too_long     = rsp_long_ff;

endmodule
